FILE: hw/rtl/iida_pkg.sv
// Shared types and constants for the indexed insert/delete array.
`default_nettype none

package iida_pkg;

  // Fixed payload widths of the request and response channels
  localparam int OP_W      = 3;
  localparam int POS_W     = 5;
  localparam int VAL_W     = 32;
  localparam int STAT_W    = 2;
  localparam int FILL_W    = 5;

  // Widest cell index the broadcast bus carries (depth up to 1024)
  localparam int IDX_MAX_W = 10;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_GET    = 3'd2,
    OP_SET    = 3'd3,
    OP_INSERT = 3'd4,
    OP_REMOVE = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Broadcast control from the request decoder to every cell
  typedef struct packed {
    logic                 wr_en;    // load the new word at idx
    logic                 up_en;    // cells above idx take the left neighbor
    logic                 down_en;  // cells at and above idx take the right neighbor
    logic [IDX_MAX_W-1:0] idx;      // target cell, also the read select
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/iida_if.sv
// Request and response channel interfaces.
`default_nettype none

interface iida_req_if;
  import iida_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] item_value;

  modport source (output valid, output op, output position, output item_value, input ready);
  modport sink   (input valid, input op, input position, input item_value, output ready);
endinterface

interface iida_rsp_if;
  import iida_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] read_value;
  logic [STAT_W-1:0]       status;
  logic [FILL_W-1:0]       fill_count;
  logic                    is_empty;

  modport source (output valid, output read_value, output status, output fill_count,
                  output is_empty, input ready);
  modport sink   (input valid, input read_value, input status, input fill_count,
                  input is_empty, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/iida_cell.sv
// One storage cell of the array chain: holds one word, shifts with its neighbors.
`default_nettype none

module iida_cell #(
  parameter int WORD_WIDTH = 32,
  parameter int INDEX      = 0
) (
  input  wire logic                   clk,
  input  wire iida_pkg::cell_ctrl_t   ctrl,
  input  wire logic [WORD_WIDTH-1:0]  word,
  input  wire logic [WORD_WIDTH-1:0]  left,
  input  wire logic [WORD_WIDTH-1:0]  right,
  output logic      [WORD_WIDTH-1:0]  q,
  output logic      [WORD_WIDTH-1:0]  rd_word
);
  import iida_pkg::*;

  localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(INDEX);

  logic above;
  logic at;

  assign above = MY_IDX > ctrl.idx;
  assign at    = MY_IDX == ctrl.idx;

  // Insert: shift up above the slot, slot takes the new word via wr_en.
  // Remove: slot and everything above take the right neighbor.
  always_ff @(posedge clk) begin
    if (ctrl.up_en && above) begin
      q <= left;
    end else if (ctrl.down_en && (above || at)) begin
      q <= right;
    end else if (ctrl.wr_en && at) begin
      q <= word;
    end
  end

  // Masked read tap; the top ORs all taps together
  assign rd_word = at ? q : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/indexed_insert_delete_array.sv
// Top level of the indexed insert/delete array built as a chain of cells.
// ---------------------------------------------------------------------------
// Ordered array of up to DEPTH words with a fill count.
// Request channel (req): op, position, item_value. Ops are push, pop, get,
//   set, insert and remove; codes 6 and 7 do nothing and report ok.
// Response channel (rsp): read_value, status, fill_count, is_empty, exactly
//   one response transaction per request transaction.
// Every cell updates in parallel with its neighbors, so insert and remove
//   shift the whole array in the same cycle as any other op.
// Latency: the response is registered, valid the cycle after acceptance.
// Throughput: one request per cycle unless stalled; the output register lets
//   a new request in the same cycle the pending response is taken.
// Stall: while rsp.ready is low with a response pending, req.ready drops and
//   the response holds.
// Reset (rst, synchronous): count goes to zero and the response register
//   empties. Cell contents are not cleared; an entry is never read before it
//   has been written.
// Failed requests (range, empty, full) leave the array and count untouched.
// ---------------------------------------------------------------------------
`default_nettype none

module indexed_insert_delete_array #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  iida_req_if.sink   req,
  iida_rsp_if.source rsp
);
  import iida_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  // Common compare width for count, position and depth
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CMP_W-1:0] DEPTH_X = CMP_W'(DEPTH);

  // Fill count
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // Response register
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_value;
  status_t                 out_status;
  logic [FILL_W-1:0]       out_fill;
  logic                    out_empty;

  logic                    accept;
  logic [CMP_W-1:0]        cnt_x;
  logic [CMP_W-1:0]        pos_x;
  op_t                     op;
  status_t                 status_next;
  cell_ctrl_t              ctrl;
  logic                    rd_ok;

  logic [WORD_WIDTH-1:0]   word;
  logic [WORD_WIDTH-1:0]   rd_word;
  logic signed [63:0]      val_ext;
  logic signed [63:0]      rd_ext;

  logic [WORD_WIDTH-1:0]   cell_q  [DEPTH];
  logic [WORD_WIDTH-1:0]   cell_rd [DEPTH];

  // Handshake: take a request whenever the output register is free or draining
  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign cnt_x = CMP_W'(count);
  assign pos_x = CMP_W'(req.position);
  assign op    = op_t'(req.op);

  // Incoming value: sign-extend, then keep the stored word width
  assign val_ext = 64'(req.item_value);
  assign word    = val_ext[WORD_WIDTH-1:0];

  // Request decode: status, new count and the broadcast to the cells
  always_comb begin
    status_next  = ST_OK;
    count_next   = count;
    rd_ok        = 1'b0;
    ctrl.wr_en   = 1'b0;
    ctrl.up_en   = 1'b0;
    ctrl.down_en = 1'b0;
    ctrl.idx     = IDX_MAX_W'(pos_x);
    unique case (op)
      OP_PUSH: begin
        ctrl.idx = IDX_MAX_W'(cnt_x);
        if (cnt_x >= DEPTH_X) begin
          status_next = ST_FULL;
        end else begin
          ctrl.wr_en = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      OP_GET: begin
        if (pos_x >= cnt_x) begin
          status_next = ST_RANGE;
        end else begin
          rd_ok = 1'b1;
        end
      end
      OP_SET: begin
        if (pos_x >= cnt_x) begin
          status_next = ST_RANGE;
        end else begin
          ctrl.wr_en = 1'b1;
        end
      end
      OP_INSERT: begin
        // index is checked before fullness
        if (pos_x > cnt_x) begin
          status_next = ST_RANGE;
        end else if (cnt_x >= DEPTH_X) begin
          status_next = ST_FULL;
        end else begin
          ctrl.wr_en = 1'b1;
          ctrl.up_en = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (pos_x >= cnt_x) begin
          status_next = ST_RANGE;
        end else begin
          ctrl.down_en = 1'b1;
          count_next   = count - CNT_W'(1);
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
    // Cells only move on an accepted transaction
    if (!accept) begin
      ctrl.wr_en   = 1'b0;
      ctrl.up_en   = 1'b0;
      ctrl.down_en = 1'b0;
    end
  end

  // The chain: each cell sees its left and right neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] left_in;
    logic [WORD_WIDTH-1:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = cell_q[i];
    end else begin : g_mid_l
      assign left_in = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_in = cell_q[i];
    end else begin : g_mid_r
      assign right_in = cell_q[i+1];
    end

    iida_cell #(
      .WORD_WIDTH (WORD_WIDTH),
      .INDEX      (i)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .word    (word),
      .left    (left_in),
      .right   (right_in),
      .q       (cell_q[i]),
      .rd_word (cell_rd[i])
    );
  end

  // Only the selected cell drives a nonzero tap
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  assign rd_ext = 64'(signed'(rd_word));

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Response payload, loaded on acceptance
  always_ff @(posedge clk) begin
    if (accept) begin
      out_value  <= rd_ok ? rd_ext[VAL_W-1:0] : '0;
      out_status <= status_next;
      out_fill   <= FILL_W'(CMP_W'(count_next));
      out_empty  <= (count_next == '0);
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_value;
  assign rsp.status     = out_status;
  assign rsp.fill_count = out_fill;
  assign rsp.is_empty   = out_empty;

  // Count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(count) <= DEPTH_X)
    else $error("fill count above capacity");

  // A pending response reports the current fill state
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_empty == (count == '0)))
    else $error("is_empty disagrees with fill count");

  // A failed request leaves the count unchanged
  a_fail_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && status_next != ST_OK) |=> (count == $past(count)))
    else $error("count moved on a failed request");

  // Read data is zero unless the request succeeded
  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_OK) |-> (out_value == '0))
    else $error("read value nonzero on error status");

endmodule

`default_nettype wire
